// File: hw/rtl/fecs_pkg.sv
// Package: shared constants and types for the fractional event clock scheduler.
`default_nettype none
package fecs_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int FRAC_BITS  = 16;

    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SLOT_IDX_W = 4;
    localparam int CLK_W      = 16;
    localparam int ACC_W      = 32;
    localparam int PERIOD_W   = 31;
    localparam int TOTAL_W    = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH          = 2'd0,
        CMD_POLL_SOUND    = 2'd1,
        CMD_POLL_SCANLINE = 2'd2,
        CMD_POLL_TIMER    = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_SOUND_PERIOD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCANLINE_PERIOD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_PERIOD     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAP_PERIOD      = CFG_IDX_W'(3);

    localparam logic [PERIOD_W-1:0] SOUND_PERIOD_RST    = PERIOD_W'(18575963);
    localparam logic [PERIOD_W-1:0] SCANLINE_PERIOD_RST = PERIOD_W'(51965000);
    localparam logic [PERIOD_W-1:0] SLOT_PERIOD_RST     = PERIOD_W'(131072);
    localparam logic [PERIOD_W-1:0] GAP_PERIOD_RST      = PERIOD_W'(2228224);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // signed accumulator reaches a non-negative period
    function automatic logic reached(input logic [ACC_W-1:0] acc,
                                     input logic [PERIOD_W-1:0] period);
        return !acc[ACC_W-1] && (acc[PERIOD_W-1:0] >= period);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fecs_ifs.sv
// Interfaces: command item, result item and configuration write channels.
`default_nettype none
interface fecs_item_if import fecs_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [CLK_W-1:0] clock_count;

    modport source(output valid, command, clock_count, input ready);
    modport sink(input valid, command, clock_count, output ready);
endinterface

interface fecs_res_if import fecs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  event_fired;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [TOTAL_W-1:0]    cycle_total;

    modport source(output valid, event_fired, slot_index, cycle_total, input ready);
    modport sink(input valid, event_fired, slot_index, cycle_total, output ready);
endinterface

interface fecs_cfg_if import fecs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fractional_event_clock_scheduler_top.sv
// Top level: fractional event clock scheduler with three 16.16 phase accumulators.
`default_nettype none
// Takes one command item per cycle while results are taken, and returns one result
// item per command, registered in the cycle after acceptance. The whole item
// (64-bit cycle add, or one compare and subtract of an accumulator against its
// period) settles combinationally into the state and result registers, so
// sustained rate is one item per clock while o_res.ready holds. i_item.ready is
// high while the result register is empty or being taken in the same cycle.
// Period registers are written through i_cfg, which is always ready; writes to
// indexes beyond 3 are dropped and data is masked to 31 bits.
module fractional_event_clock_scheduler_top import fecs_pkg::*; (
    input  wire            i_clk,
    input  wire            i_rst_n,
    fecs_item_if.sink      i_item,
    fecs_res_if.source     o_res,
    fecs_cfg_if.sink       i_cfg
);

    logic [PERIOD_W-1:0]   r_sound_period;
    logic [PERIOD_W-1:0]   r_scanline_period;
    logic [PERIOD_W-1:0]   r_slot_period;
    logic [PERIOD_W-1:0]   r_gap_period;

    logic [TOTAL_W-1:0]    r_cycle;
    logic [ACC_W-1:0]      r_sound_acc;
    logic [ACC_W-1:0]      r_scan_acc;
    logic [ACC_W-1:0]      r_timer_acc;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_in_gap;

    logic                  r_out_valid;
    logic                  r_fired;
    logic [SLOT_IDX_W-1:0] r_slot_out;
    logic [TOTAL_W-1:0]    r_total;

    logic [TOTAL_W-1:0]    n_cycle;
    logic [ACC_W-1:0]      n_sound_acc;
    logic [ACC_W-1:0]      n_scan_acc;
    logic [ACC_W-1:0]      n_timer_acc;
    logic [SLOT_W-1:0]     n_slot;
    logic                  n_in_gap;
    logic                  n_fired;
    logic [SLOT_IDX_W-1:0] n_slot_out;

    logic                  accept;
    logic [ACC_W-1:0]      frac;
    logic [PERIOD_W-1:0]   timer_until;

    assign i_item.ready = !r_out_valid || o_res.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.event_fired = r_fired;
    assign o_res.slot_index  = r_slot_out;
    assign o_res.cycle_total = r_total;

    assign frac        = ACC_W'(i_item.clock_count) << FRAC_BITS;
    assign timer_until = r_in_gap ? r_gap_period : r_slot_period;

    always_comb begin
        n_cycle     = r_cycle;
        n_sound_acc = r_sound_acc;
        n_scan_acc  = r_scan_acc;
        n_timer_acc = r_timer_acc;
        n_slot      = r_slot;
        n_in_gap    = r_in_gap;
        n_fired     = 1'b0;
        n_slot_out  = '0;
        case (i_item.command)
            CMD_PUSH: begin
                n_cycle     = r_cycle + TOTAL_W'(i_item.clock_count);
                n_sound_acc = r_sound_acc + frac;
                n_scan_acc  = r_scan_acc + frac;
                n_timer_acc = r_timer_acc + frac;
            end
            CMD_POLL_SOUND: begin
                if (reached(r_sound_acc, r_sound_period)) begin
                    n_sound_acc = r_sound_acc - ACC_W'(r_sound_period);
                    n_fired     = 1'b1;
                end
            end
            CMD_POLL_SCANLINE: begin
                if (reached(r_scan_acc, r_scanline_period)) begin
                    n_scan_acc = r_scan_acc - ACC_W'(r_scanline_period);
                    n_fired    = 1'b1;
                end
            end
            CMD_POLL_TIMER: begin
                if (reached(r_timer_acc, timer_until)) begin
                    n_timer_acc = r_timer_acc - ACC_W'(timer_until);
                    n_fired     = 1'b1;
                    n_slot_out  = SLOT_IDX_W'(r_slot);
                    if (r_slot == LAST_SLOT) begin
                        n_slot   = '0;
                        n_in_gap = 1'b1;
                    end else begin
                        n_slot   = r_slot + SLOT_W'(1);
                        n_in_gap = 1'b0;
                    end
                end
            end
            default: begin
                n_fired = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_period    <= SOUND_PERIOD_RST;
            r_scanline_period <= SCANLINE_PERIOD_RST;
            r_slot_period     <= SLOT_PERIOD_RST;
            r_gap_period      <= GAP_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SOUND_PERIOD:    r_sound_period    <= i_cfg.data[PERIOD_W-1:0];
                REG_SCANLINE_PERIOD: r_scanline_period <= i_cfg.data[PERIOD_W-1:0];
                REG_SLOT_PERIOD:     r_slot_period     <= i_cfg.data[PERIOD_W-1:0];
                REG_GAP_PERIOD:      r_gap_period      <= i_cfg.data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle     <= '0;
            r_sound_acc <= '0;
            r_scan_acc  <= '0;
            r_timer_acc <= '0;
            r_slot      <= '0;
            r_in_gap    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cycle     <= n_cycle;
                r_sound_acc <= n_sound_acc;
                r_scan_acc  <= n_scan_acc;
                r_timer_acc <= n_timer_acc;
                r_slot      <= n_slot;
                r_in_gap    <= n_in_gap;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fired    <= n_fired;
            r_slot_out <= n_slot_out;
            r_total    <= n_cycle;
        end
    end

`ifndef SYNTHESIS
    a_gap_at_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_gap |-> (r_slot == '0))
        else $error("gap period active away from slot 0");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("slot counter out of range");

    a_slot_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_fired || (r_slot_out == '0)))
        else $error("slot index reported without a fire");

    a_push_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.command == CMD_PUSH)) |=>
            (r_total == $past(r_cycle) + TOTAL_W'($past(i_item.clock_count))))
        else $error("cycle total not advanced by pushed count");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_fractional_event_clock_scheduler_top.sv
// Testbench for the fractional event clock scheduler: directed and random commands checked per item.
module tb_fractional_event_clock_scheduler_top;
    import fecs_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic                  fired;
        logic [SLOT_IDX_W-1:0] slot;
        logic [TOTAL_W-1:0]    total;
    } t_sched_out;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fecs_item_if item_if ();
    fecs_res_if  res_if ();
    fecs_cfg_if  cfg_if ();

    fractional_event_clock_scheduler_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // scheduler state as the block should hold it
    logic [PERIOD_W-1:0] snd_per;
    logic [PERIOD_W-1:0] line_per;
    logic [PERIOD_W-1:0] slot_per;
    logic [PERIOD_W-1:0] gap_per;
    logic [TOTAL_W-1:0]  cycles_seen;
    logic [ACC_W-1:0]    snd_acc;
    logic [ACC_W-1:0]    line_acc;
    logic [ACC_W-1:0]    tmr_acc;
    int                  slot_at;
    logic                in_gap;

    t_sched_out pending_outcomes[$];
    int errors      = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int rx_tick     = 0;
    int burst_left  = 0;
    int gap_max     = 0;

    always #5 clk = ~clk;

    function automatic logic is_due(input logic [ACC_W-1:0] acc, input logic [ACC_W-1:0] per);
        return !acc[ACC_W-1] && (acc >= per);
    endfunction

    function automatic t_sched_out advance_scheduler(input t_cmd cmd,
                                                     input logic [CLK_W-1:0] cnt);
        t_sched_out       r;
        logic [ACC_W-1:0] step;
        logic [ACC_W-1:0] span;
        r.fired = 1'b0;
        r.slot  = '0;
        case (cmd)
            CMD_PUSH: begin
                step = ACC_W'(cnt) << FRAC_BITS;
                cycles_seen += TOTAL_W'(cnt);
                snd_acc  += step;
                line_acc += step;
                tmr_acc  += step;
            end
            CMD_POLL_SOUND: begin
                if (is_due(snd_acc, {1'b0, snd_per})) begin
                    snd_acc -= {1'b0, snd_per};
                    r.fired = 1'b1;
                end
            end
            CMD_POLL_SCANLINE: begin
                if (is_due(line_acc, {1'b0, line_per})) begin
                    line_acc -= {1'b0, line_per};
                    r.fired = 1'b1;
                end
            end
            default: begin
                span = {1'b0, (in_gap ? gap_per : slot_per)};
                if (is_due(tmr_acc, span)) begin
                    tmr_acc -= span;
                    r.fired = 1'b1;
                    r.slot  = SLOT_IDX_W'(slot_at);
                    slot_at++;
                    if (slot_at >= SLOT_COUNT) begin
                        slot_at = 0;
                        in_gap  = 1'b1;
                    end else begin
                        in_gap = 1'b0;
                    end
                end
            end
        endcase
        r.total = cycles_seen;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    // results checked first, then the item accepted on the same edge is predicted
    always @(posedge clk) begin
        t_sched_out want;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (pending_outcomes.size() == 0) begin
                    note_mismatch("unexpected item", res_if.cycle_total, 64'd0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (res_if.event_fired !== want.fired)
                        note_mismatch("event_fired", res_if.event_fired, want.fired);
                    if (res_if.slot_index !== want.slot)
                        note_mismatch("slot_index", res_if.slot_index, want.slot);
                    if (res_if.cycle_total !== want.total)
                        note_mismatch("cycle_total", res_if.cycle_total, want.total);
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_SOUND_PERIOD:    snd_per  = cfg_if.data[PERIOD_W-1:0];
                    REG_SCANLINE_PERIOD: line_per = cfg_if.data[PERIOD_W-1:0];
                    REG_SLOT_PERIOD:     slot_per = cfg_if.data[PERIOD_W-1:0];
                    REG_GAP_PERIOD:      gap_per  = cfg_if.data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready)
                pending_outcomes.push_back(advance_scheduler(item_if.command,
                                                             item_if.clock_count));
        end
    end

    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL fractional_event_clock_scheduler_top");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= ((rx_tick % 5) != 2);
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [CLK_W-1:0] cnt);
        int gap;
        if (burst_left <= 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            repeat (gap) begin
                @(negedge clk);
                item_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        item_if.valid       <= 1'b1;
        item_if.command     <= cmd;
        item_if.clock_count <= cnt;
        do @(posedge clk); while (item_if.ready !== 1'b1);
    endtask

    task automatic send_random(input t_cmd focus);
        int               roll;
        t_cmd             cmd;
        logic [CLK_W-1:0] cnt;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            cmd = focus;
        else
            cmd = t_cmd'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 60)
            cnt = CLK_W'($urandom_range(0, 4));
        else if (roll < 85)
            cnt = CLK_W'($urandom());
        else if (roll < 92)
            cnt = '1;
        else
            cnt = CLK_W'($urandom_range(0, 255));
        send_item(cmd, cnt);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_settled();
        @(negedge clk);
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return CFG_DATA_W'($urandom_range(1, 32'h0004_0000));
        if (roll < 60) return 32'd1;
        if (roll < 70) return 32'h7FFF_FFFF;
        if (roll < 75) return 32'h8000_0000;  // masks to a zero period
        return $urandom();
    endfunction

    task automatic reset_scheduler();
        snd_per     = SOUND_PERIOD_RST;
        line_per    = SCANLINE_PERIOD_RST;
        slot_per    = SLOT_PERIOD_RST;
        gap_per     = GAP_PERIOD_RST;
        cycles_seen = '0;
        snd_acc     = '0;
        line_acc    = '0;
        tmr_acc     = '0;
        slot_at     = 0;
        in_gap      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic test_directed();
        rx_mode = 0;
        gap_max = 0;
        // empty accumulators never fire
        send_item(CMD_POLL_SOUND, '0);
        send_item(CMD_POLL_SCANLINE, '0);
        send_item(CMD_POLL_TIMER, '1);
        send_item(CMD_PUSH, '0);
        // largest push turns every accumulator negative
        send_item(CMD_PUSH, '1);
        send_item(CMD_POLL_TIMER, '0);
        send_item(CMD_POLL_SOUND, '0);
        // wraps back through zero
        send_item(CMD_PUSH, 16'd1);
        send_item(CMD_PUSH, 16'd800);
        send_item(CMD_POLL_SOUND, '0);
        send_item(CMD_POLL_SOUND, '0);
        send_item(CMD_POLL_SOUND, '0);
        send_item(CMD_POLL_SCANLINE, '0);
        send_item(CMD_POLL_TIMER, '0);
        send_item(CMD_POLL_TIMER, '0);
        wait_settled();
        write_reg(REG_SOUND_PERIOD, 32'h8000_0000);
        write_reg(CFG_IDX_W'(4), 32'h0000_0001);
        write_reg('1, 32'h0000_0001);
        write_reg(REG_SLOT_PERIOD, 32'd1);
        write_reg(REG_GAP_PERIOD, 32'h7FFF_FFFF);
        // zero period fires while the accumulator is non-negative and leaves it alone
        send_item(CMD_POLL_SOUND, '0);
        send_item(CMD_POLL_SOUND, '0);
        send_item(CMD_POLL_TIMER, '0);
        send_item(CMD_POLL_SCANLINE, '0);
    endtask

    task automatic test_period_sweep();
        t_cmd focus;
        for (int ph = 0; ph < 12; ph++) begin
            wait_settled();
            if (ph == 0) begin
                write_reg(REG_SOUND_PERIOD, 32'd1);
                write_reg(REG_SCANLINE_PERIOD, 32'd1);
                write_reg(REG_SLOT_PERIOD, 32'd1);
                write_reg(REG_GAP_PERIOD, 32'd1);
            end else if (ph == 1) begin
                write_reg(REG_SOUND_PERIOD, 32'h7FFF_FFFF);
                write_reg(REG_SCANLINE_PERIOD, 32'h7FFF_FFFF);
                write_reg(REG_SLOT_PERIOD, 32'h7FFF_FFFF);
                write_reg(REG_GAP_PERIOD, 32'h7FFF_FFFF);
            end else begin
                write_reg(REG_SOUND_PERIOD, pick_period());
                write_reg(REG_SCANLINE_PERIOD, pick_period());
                write_reg(REG_SLOT_PERIOD, pick_period());
                write_reg(REG_GAP_PERIOD, pick_period());
            end
            if (ph % 4 == 3)
                write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom());
            rx_mode = $urandom_range(0, 3);
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
            focus   = t_cmd'($urandom_range(0, 3));
            repeat (50) send_random(focus);
        end
    endtask

    task automatic test_output_stall();
        wait_settled();
        rx_mode = 0;
        gap_max = 0;
        @(posedge clk);
        hold_left = 300;
        repeat (30) send_random(CMD_PUSH);
        wait_settled();
        rx_mode = 2;
        repeat (10) send_random(CMD_POLL_TIMER);
    endtask

    initial begin
        item_if.valid       = 1'b0;
        item_if.command     = CMD_PUSH;
        item_if.clock_count = '0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        reset_scheduler();
        test_directed();
        test_period_sweep();
        test_output_stall();
        wait_settled();
        repeat (5) @(posedge clk);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("PASS fractional_event_clock_scheduler_top");
        end else begin
            $display("FAIL fractional_event_clock_scheduler_top");
        end
        $finish;
    end

endmodule
